>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that also holds while reset is high.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

>>> hdl/tracpu_pkg.sv
package tracpu_pkg;

   localparam int MEM_WORDS = 1024;
   localparam int ADDR_W = $clog2(MEM_WORDS);
   localparam int WORD_W = 32;
   localparam int DIV_CNT_W = $clog2(WORD_W);

   localparam logic [1:0] FN_WRITE = 2'd0;
   localparam logic [1:0] FN_READ = 2'd1;
   localparam logic [1:0] FN_STEP = 2'd2;

   typedef enum logic [1:0] {
      RS_RUN = 2'd0,
      RS_HALT = 2'd1,
      RS_ADDR = 2'd2,
      RS_DIV0 = 2'd3
   } run_status_type;

   typedef enum logic [4:0] {
      OP_HALT = 5'd0,
      OP_LDI1 = 5'd1,
      OP_LDI2 = 5'd2,
      OP_LDD1 = 5'd3,
      OP_LDD2 = 5'd4,
      OP_MOV = 5'd5,
      OP_LDX = 5'd6,
      OP_STX = 5'd7,
      OP_STD = 5'd8,
      OP_JMP = 5'd9,
      OP_BNZ = 5'd10,
      OP_ADD = 5'd11,
      OP_SUB = 5'd12,
      OP_MUL = 5'd13,
      OP_DIV = 5'd14,
      OP_NEG = 5'd15,
      OP_CMP = 5'd16
   } opcode_type;

   typedef enum logic [2:0] {
      AS_CLEAR,
      AS_HOST,
      AS_PC,
      AS_PC1,
      AS_R1,
      AS_R2,
      AS_ARG
   } addr_sel_type;

   typedef enum logic [1:0] {
      WS_ZERO,
      WS_HOST,
      WS_R1,
      WS_R2
   } wdata_sel_type;

   typedef enum logic [1:0] {
      PC_HOLD,
      PC_INC1,
      PC_INC2,
      PC_ARG
   } pc_op_type;

   typedef enum logic [3:0] {
      R1_HOLD,
      R1_ARG,
      R1_R2,
      R1_MEM,
      R1_ADD,
      R1_SUB,
      R1_MUL,
      R1_DIV,
      R1_NEG,
      R1_CMP
   } r1_op_type;

   typedef enum logic [1:0] {
      R2_HOLD,
      R2_ARG,
      R2_MEM
   } r2_op_type;

   typedef struct packed {
      logic [1:0] func;
      logic [9:0] host_addr;
      logic signed [31:0] host_wdata;
   } req_type;

   typedef struct packed {
      logic signed [31:0] host_rdata;
      logic signed [31:0] prog_counter;
      logic signed [31:0] reg_first;
      logic signed [31:0] reg_second;
      logic [1:0] run_status;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic clr_step;
      logic ram_we;
      addr_sel_type ram_asel;
      wdata_sel_type ram_wsel;
      logic cap_op;
      logic cap_arg;
      logic cap_hrd;
      pc_op_type pc_op;
      r1_op_type r1_op;
      r2_op_type r2_op;
      logic st_set;
      run_status_type st_val;
      logic div_start;
      logic rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic host_ok;
      logic pc_ok;
      logic pc1_ok;
      logic r1_ok;
      logic r2_ok;
      logic arg_ok;
      logic r1_nz;
      logic r2_zero;
      logic running;
      opcode_type op;
      logic div_done;
      logic clr_done;
      logic rsp_free;
   } ctl_stat_type;

endpackage

>>> hdl/tracpu_ram.sv
module tracpu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input logic clock,
   input logic wr_en,
   input logic [AW-1:0] addr,
   input logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/tracpu_div.sv
module tracpu_div (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [tracpu_pkg::WORD_W-1:0] dividend,
   input logic [tracpu_pkg::WORD_W-1:0] divisor,
   output logic done,
   output logic [tracpu_pkg::WORD_W-1:0] quotient
);

   localparam int W = tracpu_pkg::WORD_W;

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [tracpu_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic neg_ff;
   logic [W-1:0] quo_ff;
   logic [W-1:0] den_ff;
   logic [W:0] rem_ff;
   logic [W:0] rem_sh;
   logic [W:0] diff;
   logic take;

   assign rem_sh = {rem_ff[W-1:0], quo_ff[W-1]};
   assign diff = rem_sh - {1'b0, den_ff};
   assign take = !diff[W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[W-1] ^ divisor[W-1];
         quo_ff <= dividend[W-1] ? (W'(0) - dividend) : dividend;
         den_ff <= divisor[W-1] ? (W'(0) - divisor) : divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[W-2:0], take};
         rem_ff <= take ? diff : rem_sh;
      end
   end

   assign done = done_ff;
   assign quotient = neg_ff ? (W'(0) - quo_ff) : quo_ff;

endmodule

>>> hdl/tracpu_datapath.sv
module tracpu_datapath (
   input logic clock,
   input logic reset,
   input tracpu_pkg::req_type req_payload,
   input tracpu_pkg::ctl_cmd_type cmd,
   output tracpu_pkg::ctl_stat_type stat,
   output logic rsp_valid,
   input logic rsp_stall,
   output tracpu_pkg::rsp_type rsp_payload
);

   localparam int W = tracpu_pkg::WORD_W;
   localparam int AW = tracpu_pkg::ADDR_W;

   logic [1:0] func_ff;
   logic [9:0] haddr_ff;
   logic [W-1:0] wdata_ff;
   logic [W-1:0] pc_ff, pc_in;
   logic [W-1:0] r1_ff, r1_in;
   logic [W-1:0] r2_ff, r2_in;
   tracpu_pkg::run_status_type status_ff, status_in;
   logic [W-1:0] op_ff;
   logic [W-1:0] arg_ff;
   logic [W-1:0] hrd_ff;
   logic [AW-1:0] clr_ff, clr_in;
   logic rsp_valid_ff, rsp_valid_in;
   tracpu_pkg::rsp_type rsp_ff;

   logic [W-1:0] haddr_ext;
   logic [W-1:0] pc1;
   logic [W-1:0] addr_full;
   logic [W-1:0] ram_wdata;
   logic [W-1:0] ram_rd;
   logic [W-1:0] mul_lo;
   logic [W-1:0] cmp_res;
   logic [W-1:0] div_q;
   logic div_done;
   tracpu_pkg::opcode_type op_dec;

   function automatic logic in_mem(input logic [W-1:0] a);
      return a < W'(tracpu_pkg::MEM_WORDS);
   endfunction

   assign haddr_ext = W'(haddr_ff);
   assign pc1 = pc_ff + W'(1);

   always_comb begin
      unique case (cmd.ram_asel)
         tracpu_pkg::AS_CLEAR: addr_full = W'(clr_ff);
         tracpu_pkg::AS_HOST: addr_full = haddr_ext;
         tracpu_pkg::AS_PC: addr_full = pc_ff;
         tracpu_pkg::AS_PC1: addr_full = pc1;
         tracpu_pkg::AS_R1: addr_full = r1_ff;
         tracpu_pkg::AS_R2: addr_full = r2_ff;
         tracpu_pkg::AS_ARG: addr_full = arg_ff;
         default: addr_full = pc_ff;
      endcase
      unique case (cmd.ram_wsel)
         tracpu_pkg::WS_ZERO: ram_wdata = '0;
         tracpu_pkg::WS_HOST: ram_wdata = wdata_ff;
         tracpu_pkg::WS_R1: ram_wdata = r1_ff;
         tracpu_pkg::WS_R2: ram_wdata = r2_ff;
         default: ram_wdata = '0;
      endcase
   end

   tracpu_ram #(
      .WIDTH(W),
      .DEPTH(tracpu_pkg::MEM_WORDS)
   ) u_ram (
      .clock(clock),
      .wr_en(cmd.ram_we),
      .addr(addr_full[AW-1:0]),
      .wr_data(ram_wdata),
      .rd_data(ram_rd)
   );

   tracpu_div u_div (
      .clock(clock),
      .reset(reset),
      .start(cmd.div_start),
      .dividend(r1_ff),
      .divisor(r2_ff),
      .done(div_done),
      .quotient(div_q)
   );

   assign mul_lo = r1_ff * r2_ff;

   always_comb begin
      if (r1_ff == r2_ff) begin
         cmp_res = '0;
      end else if ($signed(r1_ff) > $signed(r2_ff)) begin
         cmp_res = W'(1);
      end else begin
         cmp_res = '1;
      end
   end

   always_comb begin
      if (op_ff != '0 && op_ff <= W'(tracpu_pkg::OP_CMP)) begin
         op_dec = tracpu_pkg::opcode_type'(op_ff[4:0]);
      end else begin
         op_dec = tracpu_pkg::OP_HALT;
      end
   end

   always_comb begin
      unique case (cmd.pc_op)
         tracpu_pkg::PC_HOLD: pc_in = pc_ff;
         tracpu_pkg::PC_INC1: pc_in = pc1;
         tracpu_pkg::PC_INC2: pc_in = pc_ff + W'(2);
         tracpu_pkg::PC_ARG: pc_in = arg_ff;
         default: pc_in = pc_ff;
      endcase
      unique case (cmd.r1_op)
         tracpu_pkg::R1_HOLD: r1_in = r1_ff;
         tracpu_pkg::R1_ARG: r1_in = arg_ff;
         tracpu_pkg::R1_R2: r1_in = r2_ff;
         tracpu_pkg::R1_MEM: r1_in = ram_rd;
         tracpu_pkg::R1_ADD: r1_in = r1_ff + r2_ff;
         tracpu_pkg::R1_SUB: r1_in = r1_ff - r2_ff;
         tracpu_pkg::R1_MUL: r1_in = mul_lo;
         tracpu_pkg::R1_DIV: r1_in = div_q;
         tracpu_pkg::R1_NEG: r1_in = W'(0) - r1_ff;
         tracpu_pkg::R1_CMP: r1_in = cmp_res;
         default: r1_in = r1_ff;
      endcase
      unique case (cmd.r2_op)
         tracpu_pkg::R2_HOLD: r2_in = r2_ff;
         tracpu_pkg::R2_ARG: r2_in = arg_ff;
         tracpu_pkg::R2_MEM: r2_in = ram_rd;
         default: r2_in = r2_ff;
      endcase
      status_in = cmd.st_set ? cmd.st_val : status_ff;
      clr_in = cmd.clr_step ? clr_ff + 1'b1 : clr_ff;
      rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
         r1_ff <= '0;
         r2_ff <= '0;
         status_ff <= tracpu_pkg::RS_RUN;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff <= pc_in;
         r1_ff <= r1_in;
         r2_ff <= r2_in;
         status_ff <= status_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_payload.func;
         haddr_ff <= req_payload.host_addr;
         wdata_ff <= req_payload.host_wdata;
         hrd_ff <= '0;
      end else if (cmd.cap_hrd) begin
         hrd_ff <= in_mem(haddr_ext) ? ram_rd : '0;
      end
      if (cmd.cap_op) begin
         op_ff <= ram_rd;
      end
      if (cmd.cap_arg) begin
         arg_ff <= ram_rd;
      end
      if (cmd.rsp_load) begin
         rsp_ff.host_rdata <= hrd_ff;
         rsp_ff.prog_counter <= pc_ff;
         rsp_ff.reg_first <= r1_ff;
         rsp_ff.reg_second <= r2_ff;
         rsp_ff.run_status <= status_ff;
      end
   end

   always_comb begin
      stat.func = func_ff;
      stat.host_ok = in_mem(haddr_ext);
      stat.pc_ok = in_mem(pc_ff);
      stat.pc1_ok = in_mem(pc1);
      stat.r1_ok = in_mem(r1_ff);
      stat.r2_ok = in_mem(r2_ff);
      stat.arg_ok = in_mem(arg_ff);
      stat.r1_nz = (r1_ff != '0);
      stat.r2_zero = (r2_ff == '0);
      stat.running = (status_ff == tracpu_pkg::RS_RUN);
      stat.op = op_dec;
      stat.div_done = div_done;
      stat.clr_done = (clr_ff == AW'(tracpu_pkg::MEM_WORDS - 1));
      stat.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> hdl/tracpu_ctrl.sv
module tracpu_ctrl (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input tracpu_pkg::ctl_stat_type stat,
   output tracpu_pkg::ctl_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISP,
      S_HRD,
      S_OP,
      S_DEC,
      S_ARG,
      S_ARGX,
      S_VAL,
      S_DIV,
      S_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.ram_we = 1'b1;
            cmd.ram_asel = tracpu_pkg::AS_CLEAR;
            cmd.ram_wsel = tracpu_pkg::WS_ZERO;
            cmd.clr_step = 1'b1;
            if (stat.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            unique case (stat.func)
               tracpu_pkg::FN_WRITE: begin
                  cmd.ram_we = stat.host_ok;
                  cmd.ram_asel = tracpu_pkg::AS_HOST;
                  cmd.ram_wsel = tracpu_pkg::WS_HOST;
                  state_in = S_RESP;
               end
               tracpu_pkg::FN_READ: begin
                  cmd.ram_asel = tracpu_pkg::AS_HOST;
                  state_in = S_HRD;
               end
               tracpu_pkg::FN_STEP: begin
                  state_in = S_RESP;
                  if (stat.running) begin
                     if (!stat.pc_ok) begin
                        cmd.st_set = 1'b1;
                        cmd.st_val = tracpu_pkg::RS_ADDR;
                     end else begin
                        cmd.ram_asel = tracpu_pkg::AS_PC;
                        state_in = S_OP;
                     end
                  end
               end
               default: state_in = S_RESP;
            endcase
         end
         S_HRD: begin
            cmd.cap_hrd = 1'b1;
            state_in = S_RESP;
         end
         S_OP: begin
            cmd.cap_op = 1'b1;
            state_in = S_DEC;
         end
         S_DEC: begin
            state_in = S_RESP;
            case (stat.op)
               tracpu_pkg::OP_LDI1, tracpu_pkg::OP_LDI2, tracpu_pkg::OP_LDD1,
               tracpu_pkg::OP_LDD2, tracpu_pkg::OP_STD, tracpu_pkg::OP_JMP,
               tracpu_pkg::OP_BNZ: begin
                  if (stat.pc1_ok) begin
                     cmd.ram_asel = tracpu_pkg::AS_PC1;
                     state_in = S_ARG;
                  end else begin
                     cmd.st_set = 1'b1;
                     cmd.st_val = tracpu_pkg::RS_ADDR;
                  end
               end
               tracpu_pkg::OP_MOV: begin
                  cmd.r1_op = tracpu_pkg::R1_R2;
                  cmd.pc_op = tracpu_pkg::PC_INC1;
               end
               tracpu_pkg::OP_LDX: begin
                  if (stat.r2_ok) begin
                     cmd.ram_asel = tracpu_pkg::AS_R2;
                     state_in = S_VAL;
                  end else begin
                     cmd.st_set = 1'b1;
                     cmd.st_val = tracpu_pkg::RS_ADDR;
                  end
               end
               tracpu_pkg::OP_STX: begin
                  if (stat.r1_ok) begin
                     cmd.ram_we = 1'b1;
                     cmd.ram_asel = tracpu_pkg::AS_R1;
                     cmd.ram_wsel = tracpu_pkg::WS_R2;
                     cmd.pc_op = tracpu_pkg::PC_INC1;
                  end else begin
                     cmd.st_set = 1'b1;
                     cmd.st_val = tracpu_pkg::RS_ADDR;
                  end
               end
               tracpu_pkg::OP_ADD: begin
                  cmd.r1_op = tracpu_pkg::R1_ADD;
                  cmd.pc_op = tracpu_pkg::PC_INC1;
               end
               tracpu_pkg::OP_SUB: begin
                  cmd.r1_op = tracpu_pkg::R1_SUB;
                  cmd.pc_op = tracpu_pkg::PC_INC1;
               end
               tracpu_pkg::OP_MUL: begin
                  cmd.r1_op = tracpu_pkg::R1_MUL;
                  cmd.pc_op = tracpu_pkg::PC_INC1;
               end
               tracpu_pkg::OP_DIV: begin
                  if (stat.r2_zero) begin
                     cmd.st_set = 1'b1;
                     cmd.st_val = tracpu_pkg::RS_DIV0;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in = S_DIV;
                  end
               end
               tracpu_pkg::OP_NEG: begin
                  cmd.r1_op = tracpu_pkg::R1_NEG;
                  cmd.pc_op = tracpu_pkg::PC_INC1;
               end
               tracpu_pkg::OP_CMP: begin
                  cmd.r1_op = tracpu_pkg::R1_CMP;
                  cmd.pc_op = tracpu_pkg::PC_INC1;
               end
               default: begin
                  cmd.st_set = 1'b1;
                  cmd.st_val = tracpu_pkg::RS_HALT;
               end
            endcase
         end
         S_ARG: begin
            cmd.cap_arg = 1'b1;
            state_in = S_ARGX;
         end
         S_ARGX: begin
            state_in = S_RESP;
            case (stat.op)
               tracpu_pkg::OP_LDI1: begin
                  cmd.r1_op = tracpu_pkg::R1_ARG;
                  cmd.pc_op = tracpu_pkg::PC_INC2;
               end
               tracpu_pkg::OP_LDI2: begin
                  cmd.r2_op = tracpu_pkg::R2_ARG;
                  cmd.pc_op = tracpu_pkg::PC_INC2;
               end
               tracpu_pkg::OP_LDD1, tracpu_pkg::OP_LDD2: begin
                  if (stat.arg_ok) begin
                     cmd.ram_asel = tracpu_pkg::AS_ARG;
                     state_in = S_VAL;
                  end else begin
                     cmd.st_set = 1'b1;
                     cmd.st_val = tracpu_pkg::RS_ADDR;
                  end
               end
               tracpu_pkg::OP_STD: begin
                  if (stat.arg_ok) begin
                     cmd.ram_we = 1'b1;
                     cmd.ram_asel = tracpu_pkg::AS_ARG;
                     cmd.ram_wsel = tracpu_pkg::WS_R1;
                     cmd.pc_op = tracpu_pkg::PC_INC2;
                  end else begin
                     cmd.st_set = 1'b1;
                     cmd.st_val = tracpu_pkg::RS_ADDR;
                  end
               end
               tracpu_pkg::OP_JMP: begin
                  cmd.pc_op = tracpu_pkg::PC_ARG;
               end
               tracpu_pkg::OP_BNZ: begin
                  cmd.pc_op = stat.r1_nz ? tracpu_pkg::PC_ARG : tracpu_pkg::PC_INC2;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_VAL: begin
            state_in = S_RESP;
            case (stat.op)
               tracpu_pkg::OP_LDD1: begin
                  cmd.r1_op = tracpu_pkg::R1_MEM;
                  cmd.pc_op = tracpu_pkg::PC_INC2;
               end
               tracpu_pkg::OP_LDD2: begin
                  cmd.r2_op = tracpu_pkg::R2_MEM;
                  cmd.pc_op = tracpu_pkg::PC_INC2;
               end
               default: begin
                  cmd.r1_op = tracpu_pkg::R1_MEM;
                  cmd.pc_op = tracpu_pkg::PC_INC1;
               end
            endcase
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.r1_op = tracpu_pkg::R1_DIV;
               cmd.pc_op = tracpu_pkg::PC_INC1;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

>>> hdl/two_register_accumulator_cpu_top.sv
// A host write goes from dispatch straight to the response state, a host read through a
// read state; a step fetches and decodes the opcode, then fetches an operand word if any,
// reads the data word of a direct or indirect load and waits for the divider on a divide;
// a step on a stopped machine or at a faulting pc goes straight to the response state.
// One item is in work at a time; the next request beat is taken in the cycle after the
// result is loaded into the output register. Synchronous reset clears pc, both registers
// and status, then zeroes every memory word, one word a cycle, before the first request beat is taken.
module two_register_accumulator_cpu_top (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input tracpu_pkg::req_type req_payload,
   output logic rsp_valid,
   input logic rsp_stall,
   output tracpu_pkg::rsp_type rsp_payload
);

   tracpu_pkg::ctl_cmd_type cmd;
   tracpu_pkg::ctl_stat_type stat;

   tracpu_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .stat(stat),
      .cmd(cmd)
   );

   tracpu_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .req_payload(req_payload),
      .cmd(cmd),
      .stat(stat),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

>>> hdl/tracpu_checker.sv
`include "assert_macros.svh"

module tracpu_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input tracpu_pkg::rsp_type rsp_payload
);

   logic [1:0] pend_ff, pend_in;
   logic halted_ff, halted_in;
   logic req_beat;
   logic rsp_beat;
   logic rsp_stopped;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;
   assign rsp_stopped = (rsp_payload.run_status != tracpu_pkg::RS_RUN);

   always_comb begin
      pend_in = pend_ff + 2'(req_beat) - 2'(rsp_beat);
      halted_in = halted_ff || (rsp_beat && rsp_stopped);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         halted_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         halted_ff <= halted_in;
      end
   end

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_payload))
   `ASSERT_CLK(a_rsp_has_req, clock, reset, rsp_valid |-> pend_ff != 2'd0 && pend_ff != 2'd3)
   `ASSERT_CLK(a_stop_sticks, clock, reset, rsp_valid && halted_ff |-> rsp_stopped)
   `ASSERT_CLK_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid)

endmodule

bind two_register_accumulator_cpu_top tracpu_checker u_checker (.*);

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam logic [1:0] FN_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 840;
   localparam int HOLD_AT = 300;
   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      tracpu_pkg::req_type req;
      logic fixed;
      tracpu_pkg::rsp_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   tracpu_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   tracpu_pkg::rsp_type rsp_payload;

   logic [31:0] mem_q [tracpu_pkg::MEM_WORDS];
   logic [31:0] pc_q;
   logic [31:0] r1_q;
   logic [31:0] r2_q;
   tracpu_pkg::run_status_type st_q;

   tracpu_pkg::rsp_type state_q [$];
   row_type dir_q [$];
   int n_err = 0;
   int n_rsp = 0;
   int n_items = 0;
   int n_steps = 0;
   int n_reads = 0;
   int n_writes = 0;
   int n_spare = 0;
   int quiet = 0;
   bit req_calm = 1'b0;

   two_register_accumulator_cpu_top u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always #6 clock = ~clock;

   function automatic logic in_mem(logic [31:0] a);
      return a < 32'(tracpu_pkg::MEM_WORDS);
   endfunction

   function automatic logic takes_arg(tracpu_pkg::opcode_type code);
      case (code)
         tracpu_pkg::OP_LDI1, tracpu_pkg::OP_LDI2, tracpu_pkg::OP_LDD1,
         tracpu_pkg::OP_LDD2, tracpu_pkg::OP_STD, tracpu_pkg::OP_JMP,
         tracpu_pkg::OP_BNZ: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic tracpu_pkg::run_status_type cpu_step();
      logic [31:0] op;
      logic [31:0] arg;
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] quo;
      tracpu_pkg::opcode_type code;
      arg = '0;
      if (!in_mem(pc_q)) return tracpu_pkg::RS_ADDR;
      op = mem_q[pc_q[9:0]];
      if (op > 32'(tracpu_pkg::OP_CMP)) return tracpu_pkg::RS_HALT;
      code = tracpu_pkg::opcode_type'(op[4:0]);
      if (takes_arg(code)) begin
         if (!in_mem(pc_q + 32'd1)) return tracpu_pkg::RS_ADDR;
         arg = mem_q[pc_q[9:0] + 10'd1];
      end
      case (code)
         tracpu_pkg::OP_LDI1: begin
            r1_q = arg;
            pc_q = pc_q + 32'd2;
         end
         tracpu_pkg::OP_LDI2: begin
            r2_q = arg;
            pc_q = pc_q + 32'd2;
         end
         tracpu_pkg::OP_LDD1: begin
            if (!in_mem(arg)) return tracpu_pkg::RS_ADDR;
            r1_q = mem_q[arg[9:0]];
            pc_q = pc_q + 32'd2;
         end
         tracpu_pkg::OP_LDD2: begin
            if (!in_mem(arg)) return tracpu_pkg::RS_ADDR;
            r2_q = mem_q[arg[9:0]];
            pc_q = pc_q + 32'd2;
         end
         tracpu_pkg::OP_MOV: begin
            r1_q = r2_q;
            pc_q = pc_q + 32'd1;
         end
         tracpu_pkg::OP_LDX: begin
            if (!in_mem(r2_q)) return tracpu_pkg::RS_ADDR;
            r1_q = mem_q[r2_q[9:0]];
            pc_q = pc_q + 32'd1;
         end
         tracpu_pkg::OP_STX: begin
            if (!in_mem(r1_q)) return tracpu_pkg::RS_ADDR;
            mem_q[r1_q[9:0]] = r2_q;
            pc_q = pc_q + 32'd1;
         end
         tracpu_pkg::OP_STD: begin
            if (!in_mem(arg)) return tracpu_pkg::RS_ADDR;
            mem_q[arg[9:0]] = r1_q;
            pc_q = pc_q + 32'd2;
         end
         tracpu_pkg::OP_JMP: pc_q = arg;
         tracpu_pkg::OP_BNZ: pc_q = (r1_q != 32'd0) ? arg : pc_q + 32'd2;
         tracpu_pkg::OP_ADD: begin
            r1_q = r1_q + r2_q;
            pc_q = pc_q + 32'd1;
         end
         tracpu_pkg::OP_SUB: begin
            r1_q = r1_q - r2_q;
            pc_q = pc_q + 32'd1;
         end
         tracpu_pkg::OP_MUL: begin
            r1_q = r1_q * r2_q;
            pc_q = pc_q + 32'd1;
         end
         tracpu_pkg::OP_DIV: begin
            if (r2_q == 32'd0) return tracpu_pkg::RS_DIV0;
            ma = r1_q[31] ? -r1_q : r1_q;
            mb = r2_q[31] ? -r2_q : r2_q;
            quo = ma / mb;
            r1_q = (r1_q[31] ^ r2_q[31]) ? -quo : quo;
            pc_q = pc_q + 32'd1;
         end
         tracpu_pkg::OP_NEG: begin
            r1_q = -r1_q;
            pc_q = pc_q + 32'd1;
         end
         tracpu_pkg::OP_CMP: begin
            if (r1_q == r2_q) r1_q = 32'd0;
            else if ($signed(r1_q) > $signed(r2_q)) r1_q = 32'd1;
            else r1_q = 32'hFFFF_FFFF;
            pc_q = pc_q + 32'd1;
         end
         default: return tracpu_pkg::RS_HALT;
      endcase
      return tracpu_pkg::RS_RUN;
   endfunction

   function automatic tracpu_pkg::rsp_type cpu_advance(tracpu_pkg::req_type r);
      tracpu_pkg::rsp_type e;
      e = '0;
      case (r.func)
         tracpu_pkg::FN_WRITE: mem_q[r.host_addr] = r.host_wdata;
         tracpu_pkg::FN_READ: e.host_rdata = mem_q[r.host_addr];
         tracpu_pkg::FN_STEP: if (st_q == tracpu_pkg::RS_RUN) st_q = cpu_step();
         default: ;
      endcase
      e.prog_counter = pc_q;
      e.reg_first = r1_q;
      e.reg_second = r2_q;
      e.run_status = st_q;
      return e;
   endfunction

   function automatic tracpu_pkg::req_type mk(logic [1:0] f, logic [9:0] a, logic [31:0] d);
      tracpu_pkg::req_type r;
      r.func = f;
      r.host_addr = a;
      r.host_wdata = d;
      return r;
   endfunction

   function automatic tracpu_pkg::rsp_type cpu_view(logic [31:0] rd, logic [31:0] pc,
                                                    logic [31:0] r1, logic [31:0] r2,
                                                    tracpu_pkg::run_status_type st);
      tracpu_pkg::rsp_type e;
      e.host_rdata = rd;
      e.prog_counter = pc;
      e.reg_first = r1;
      e.reg_second = r2;
      e.run_status = st;
      return e;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'h1;
         2: return 32'hFFFF_FFFF;
         3: return 32'h7FFF_FFFF;
         4: return 32'h8000_0000;
         5, 6: return 32'($urandom_range(0, tracpu_pkg::MEM_WORDS - 1));
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [9:0] rand_addr();
      case ($urandom_range(0, 5))
         0: return 10'd0;
         1: return 10'(tracpu_pkg::MEM_WORDS - 1);
         2, 3: return pc_q[9:0] + 10'($urandom_range(0, 3));
         default: return 10'($urandom());
      endcase
   endfunction

   task automatic put_req(input tracpu_pkg::req_type r);
      int unsigned gap;
      if ($urandom_range(0, 31) == 0) req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   task automatic issue(input tracpu_pkg::req_type r, input logic fixed = 1'b0,
                        input tracpu_pkg::rsp_type want = '0);
      tracpu_pkg::rsp_type e;
      e = cpu_advance(r);
      if (fixed) e = want;
      state_q.insert(state_q.size(), e);
      n_items++;
      case (r.func)
         tracpu_pkg::FN_WRITE: n_writes++;
         tracpu_pkg::FN_READ: n_reads++;
         tracpu_pkg::FN_STEP: n_steps++;
         default: n_spare++;
      endcase
      put_req(r);
   endtask

   task automatic add_row(input tracpu_pkg::req_type r, input logic fixed,
                          input tracpu_pkg::rsp_type want);
      row_type w;
      w.req = r;
      w.fixed = fixed;
      w.want = want;
      dir_q.insert(dir_q.size(), w);
   endtask

   task automatic run_op(input tracpu_pkg::opcode_type code, input logic [31:0] arg);
      logic [9:0] pc;
      pc = pc_q[9:0];
      issue(mk(tracpu_pkg::FN_WRITE, pc, 32'(code)));
      if (takes_arg(code)) issue(mk(tracpu_pkg::FN_WRITE, pc + 10'd1, arg));
      issue(mk(tracpu_pkg::FN_STEP, 10'($urandom()), $urandom()));
   endtask

   // Picks an instruction that keeps the machine running, with random operands.
   task automatic run_instr();
      tracpu_pkg::opcode_type code;
      logic [31:0] arg;
      code = tracpu_pkg::opcode_type'(5'($urandom_range(1, 16)));
      arg = '0;
      if (pc_q > 32'(tracpu_pkg::MEM_WORDS - 24)) code = tracpu_pkg::OP_JMP;
      case (code)
         tracpu_pkg::OP_LDI1, tracpu_pkg::OP_LDI2: arg = rand_word();
         tracpu_pkg::OP_LDD1, tracpu_pkg::OP_LDD2, tracpu_pkg::OP_STD:
            arg = 32'($urandom_range(0, tracpu_pkg::MEM_WORDS - 1));
         tracpu_pkg::OP_JMP, tracpu_pkg::OP_BNZ:
            arg = 32'($urandom_range(0, tracpu_pkg::MEM_WORDS - 32));
         tracpu_pkg::OP_LDX: if (!in_mem(r2_q)) begin
            code = tracpu_pkg::OP_LDI2;
            arg = 32'($urandom_range(0, tracpu_pkg::MEM_WORDS - 1));
         end
         tracpu_pkg::OP_STX: if (!in_mem(r1_q)) begin
            code = tracpu_pkg::OP_LDI1;
            arg = 32'($urandom_range(0, tracpu_pkg::MEM_WORDS - 1));
         end
         tracpu_pkg::OP_DIV: if (r2_q == 32'd0) begin
            code = tracpu_pkg::OP_LDI2;
            arg = rand_word();
         end
         default: ;
      endcase
      run_op(code, arg);
   endtask

   // Ends the program with one of the ways the machine can stop, then shows that
   // steps no longer change anything while host accesses still work.
   task automatic stop_machine();
      logic [9:0] a;
      case ($urandom_range(0, 5))
         0: issue(mk(tracpu_pkg::FN_WRITE, pc_q[9:0], 32'(tracpu_pkg::OP_HALT)));
         1: issue(mk(tracpu_pkg::FN_WRITE, pc_q[9:0], $urandom() | 32'h20));
         2: run_op(tracpu_pkg::OP_JMP,
                   $urandom_range(0, 1) ? 32'(tracpu_pkg::MEM_WORDS) + $urandom_range(0, 999)
                                        : 32'h8000_0000 | $urandom());
         3: run_op(tracpu_pkg::OP_LDD1, 32'h8000_0000 | $urandom());
         4: begin
            run_op(tracpu_pkg::OP_LDI2, 32'd0);
            run_op(tracpu_pkg::OP_DIV, 32'd0);
         end
         default: begin
            run_op(tracpu_pkg::OP_JMP, 32'(tracpu_pkg::MEM_WORDS - 1));
            issue(mk(tracpu_pkg::FN_WRITE, 10'(tracpu_pkg::MEM_WORDS - 1),
                     32'(tracpu_pkg::OP_LDI1)));
         end
      endcase
      repeat (3) issue(mk(tracpu_pkg::FN_STEP, 10'($urandom()), $urandom()));
      a = 10'($urandom());
      issue(mk(tracpu_pkg::FN_WRITE, a, $urandom()));
      issue(mk(tracpu_pkg::FN_READ, a, $urandom()));
   endtask

   task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want) begin
         n_err++;
         if (n_err <= 10)
            $display("beat %0d: %s mismatch, expected %h, got %h", n_rsp, name, want, got);
      end
   endtask

   task automatic check_rsp(input tracpu_pkg::rsp_type got);
      tracpu_pkg::rsp_type want;
      if (state_q.size() == 0) begin
         n_err++;
         if (n_err <= 10) $display("beat %0d: unexpected result %h", n_rsp, got);
         return;
      end
      want = state_q.pop_front();
      cmp_field("host_rdata", got.host_rdata, want.host_rdata);
      cmp_field("prog_counter", got.prog_counter, want.prog_counter);
      cmp_field("reg_first", got.reg_first, want.reg_first);
      cmp_field("reg_second", got.reg_second, want.reg_second);
      cmp_field("run_status", 32'(got.run_status), 32'(want.run_status));
   endtask

   initial begin : rsp_side
      int unsigned gap;
      bit calm;
      bit held;
      calm = 1'b0;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) calm = !calm;
         gap = calm ? 0 : $urandom_range(0, 6);
         if (!held && n_rsp == HOLD_AT) begin
            held = 1'b1;
            gap = gap + HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         n_rsp++;
         check_rsp(rsp_payload);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
      end
      if (quiet == QUIET_LIMIT) begin
         $display("no beat for %0d cycles, %0d results still expected", quiet, state_q.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin : req_side
      tracpu_pkg::rsp_type zero;
      int sel;
      for (int i = 0; i < tracpu_pkg::MEM_WORDS; i++) mem_q[i] = '0;
      pc_q = '0;
      r1_q = '0;
      r2_q = '0;
      st_q = tracpu_pkg::RS_RUN;
      zero = cpu_view(0, 0, 0, 0, tracpu_pkg::RS_RUN);

      add_row(mk(tracpu_pkg::FN_READ, 10'd0, 32'd0), 1'b1, zero);
      add_row(mk(tracpu_pkg::FN_READ, 10'd1023, 32'hFFFF_FFFF), 1'b1, zero);
      add_row(mk(FN_SPARE, 10'd1023, 32'hFFFF_FFFF), 1'b1, zero);
      add_row(mk(tracpu_pkg::FN_WRITE, 10'd1023, 32'h7FFF_FFFF), 1'b1, zero);
      add_row(mk(tracpu_pkg::FN_WRITE, 10'd1022, 32'h8000_0000), 1'b1, zero);
      add_row(mk(tracpu_pkg::FN_READ, 10'd1023, 32'd0), 1'b1,
              cpu_view(32'h7FFF_FFFF, 0, 0, 0, tracpu_pkg::RS_RUN));
      add_row(mk(tracpu_pkg::FN_READ, 10'd1022, 32'd0), 1'b1,
              cpu_view(32'h8000_0000, 0, 0, 0, tracpu_pkg::RS_RUN));
      add_row(mk(tracpu_pkg::FN_WRITE, 10'd0, 32'(tracpu_pkg::OP_LDI1)), 1'b0, zero);
      add_row(mk(tracpu_pkg::FN_WRITE, 10'd1, 32'h8000_0000), 1'b0, zero);
      add_row(mk(tracpu_pkg::FN_WRITE, 10'd2, 32'(tracpu_pkg::OP_LDI2)), 1'b0, zero);
      add_row(mk(tracpu_pkg::FN_WRITE, 10'd3, 32'hFFFF_FFFF), 1'b0, zero);
      add_row(mk(tracpu_pkg::FN_WRITE, 10'd4, 32'(tracpu_pkg::OP_DIV)), 1'b0, zero);
      add_row(mk(tracpu_pkg::FN_WRITE, 10'd5, 32'(tracpu_pkg::OP_NEG)), 1'b0, zero);
      add_row(mk(tracpu_pkg::FN_WRITE, 10'd6, 32'(tracpu_pkg::OP_MUL)), 1'b0, zero);
      add_row(mk(tracpu_pkg::FN_WRITE, 10'd7, 32'(tracpu_pkg::OP_CMP)), 1'b0, zero);
      add_row(mk(tracpu_pkg::FN_STEP, 10'd0, 32'd0), 1'b1,
              cpu_view(0, 2, 32'h8000_0000, 0, tracpu_pkg::RS_RUN));
      repeat (5) add_row(mk(tracpu_pkg::FN_STEP, 10'h3FF, 32'hFFFF_FFFF), 1'b0, zero);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_q[i]) issue(dir_q[i].req, dir_q[i].fixed, dir_q[i].want);

      while (n_items < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (sel < 55) run_instr();
         else if (sel < 80) issue(mk(tracpu_pkg::FN_READ, rand_addr(), $urandom()));
         else if (sel < 95) issue(mk(tracpu_pkg::FN_WRITE, rand_addr(), rand_word()));
         else issue(mk(FN_SPARE, 10'($urandom()), $urandom()));
      end
      stop_machine();
      req_valid <= 1'b0;

      while (state_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d items: %0d steps, %0d host reads, %0d host writes, %0d spare",
               n_items, n_steps, n_reads, n_writes, n_spare);
      $display("machine stopped as %s at pc %h; %0d field mismatches",
               st_q.name(), pc_q, n_err);
      if (n_err == 0 && state_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
